>>> sv/plvc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plvc_pkg
// Shared types, widths and codes for the 3D polyline viewport clipper.
// ----------------------------------------------------------------------------
package plvc_pkg;

    localparam int COORD_WIDTH     = 32;
    localparam int COORD_FRAC_BITS = 16;
    localparam int T_FRAC_BITS     = 16;
    localparam int PIXEL_WIDTH     = 16;

    localparam int DIFF_W  = COORD_WIDTH + 1;          // deltas and edge terms
    localparam int MAG_W   = COORD_WIDTH;              // magnitudes of deltas
    localparam int T_W     = T_FRAC_BITS + 1;          // t in 0 .. one plus a step
    localparam int HI_W    = MAG_W - T_FRAC_BITS;
    localparam int PHI_W   = HI_W + T_W;
    localparam int PLO_W   = T_FRAC_BITS + T_W;
    localparam int PT_W    = COORD_WIDTH + 2;          // interpolated point
    localparam int S_W     = PT_W + 2;                 // rounding workspace
    localparam int CNT_W   = $clog2(T_FRAC_BITS);
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    localparam logic [T_W-1:0] T_ONE      = T_W'(1) << T_FRAC_BITS;
    localparam logic [T_W-1:0] T_ONE_STEP = (T_W'(1) << T_FRAC_BITS) + T_W'(1);

    localparam logic [5:0] OC_LEFT   = 6'h01;
    localparam logic [5:0] OC_RIGHT  = 6'h02;
    localparam logic [5:0] OC_BOTTOM = 6'h04;
    localparam logic [5:0] OC_TOP    = 6'h08;
    localparam logic [5:0] OC_NEAR   = 6'h10;
    localparam logic [5:0] OC_FAR    = 6'h20;

    localparam logic [2:0] EDGE_NEAR = 3'd4;
    localparam logic [2:0] EDGE_FAR  = 3'd5;
    localparam logic [2:0] EDGE_LAST = 3'd5;

    typedef enum logic [2:0] {
        REG_BOX_X_LOW        = 3'd0,
        REG_BOX_X_HIGH       = 3'd1,
        REG_BOX_Y_LOW        = 3'd2,
        REG_BOX_Y_HIGH       = 3'd3,
        REG_BOX_Z_LOW        = 3'd4,
        REG_BOX_Z_HIGH       = 3'd5,
        REG_CLIP_MODE        = 3'd6,
        REG_TERMINATE_AT_END = 3'd7
    } reg_idx_t;

    typedef enum logic [1:0] {
        OP_MOVE = 2'd0,
        OP_DRAW = 2'd1,
        OP_TERM = 2'd2
    } draw_op_t;

    typedef enum logic [1:0] {
        EK_SKIP   = 2'd0,
        EK_REJECT = 2'd1,
        EK_DIRECT = 2'd2,
        EK_DIV    = 2'd3
    } edge_kind_t;

    typedef enum logic [1:0] {
        EMIT_TERM = 2'd0,
        EMIT_MOVE = 2'd1,
        EMIT_PEN  = 2'd2     // move or draw, per the pending-move flag
    } emit_sel_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] box_x_low;
        logic signed [COORD_WIDTH-1:0] box_x_high;
        logic signed [COORD_WIDTH-1:0] box_y_low;
        logic signed [COORD_WIDTH-1:0] box_y_high;
        logic signed [COORD_WIDTH-1:0] box_z_low;
        logic signed [COORD_WIDTH-1:0] box_z_high;
        logic [2:0]                    clip_mode;
        logic                          terminate_at_end;
    } plvc_cfg_t;

    typedef struct packed {
        logic      load_vertex;
        logic      eval;
        logic      clip_init;
        logic      edge_pq;
        logic      edge_chk;
        logic      div_step;
        logic      apply;
        logic      edge_next;
        logic      pt_load;
        logic      pt_sel;      // 0 start point, 1 end point
        logic      mul_lo;
        logic      mul_hi;
        logic      mul_add;
        logic      axis;        // 0 x, 1 y
        logic      emit;
        emit_sel_t emit_sel;
        logic      emit_last;
        logic      clr_move;
        logic      commit;
    } plvc_cmd_t;

    typedef struct packed {
        logic       trivial_accept;
        logic       trivial_reject;
        edge_kind_t edge_kind;
        logic       div_done;
        logic       apply_reject;
        logic       last_edge;
        logic       prev_oc_nz;
        logic       start_interp;
        logic       end_interp;
        logic       out_free;
        logic       end_term;
    } plvc_status_t;

endpackage
`default_nettype wire

>>> sv/polyline_viewport_clip_3d.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// polyline_viewport_clip_3d
// Clips a 3D polyline against a box and emits 2D pen commands.
// ----------------------------------------------------------------------------
// Vertices enter on the s_ stream, one item per vertex; pen commands leave on
// the m_ stream, zero to four items per vertex, the final one with m_tlast.
// The box and mode registers are to be written over the APB-style port only
// while idle; the block itself does not enforce this. One vertex is worked
// on at a time; s_tready is high only between vertices. Trivially accepted
// and rejected segments skip clipping. A clipped segment walks up to six
// boundaries, applying a ratio where one cuts, after the one-bit-per-cycle
// divider when the ratio is below one; each clipped end point is
// interpolated on the shared 16 by 17 bit multiplier (load, then x and y,
// low half, high half, add). The divider sets most of the worst-case time
// per vertex.
// Results sit in a one-deep output register; while m_tready is low the
// sequencer waits at its next emit, taking no further vertex while it waits.
// Reset (aresetn low, synchronous) clears the config and previous outcode,
// zeroes the previous vertex, sets the disconnected and pending-move flags.
// ----------------------------------------------------------------------------
module polyline_viewport_clip_3d
    import plvc_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [95:0]       s_tdata,   // vertex_x, vertex_y, vertex_z
    input  wire logic              s_tuser,   // strip_start
    input  wire logic              s_tlast,   // strip_end
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [31:0]            m_tdata,   // pixel_x, pixel_y
    output logic [1:0]             m_tuser,   // draw_op
    output logic                   m_tlast,   // last_of_run
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready
);

    plvc_cfg_t              cfg;
    plvc_cmd_t              cmd;
    plvc_status_t           st;
    logic [PIXEL_WIDTH-1:0] px, py;

    plvc_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    plvc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    plvc_datapath u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .cmd      (cmd),
        .st       (st),
        .in_x     (s_tdata[31:0]),
        .in_y     (s_tdata[63:32]),
        .in_z     (s_tdata[95:64]),
        .in_start (s_tuser),
        .in_end   (s_tlast),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_op     (m_tuser),
        .m_px     (px),
        .m_py     (py),
        .m_last   (m_tlast)
    );

    assign m_tdata = {py, px};

endmodule
`default_nettype wire

>>> sv/plvc_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plvc_regs
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
module plvc_regs
    import plvc_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    output plvc_cfg_t              cfg
);

    plvc_cfg_t cfg_reg, cfg_next;
    reg_idx_t  idx;
    logic      wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[4:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (idx)
                REG_BOX_X_LOW:        cfg_next.box_x_low  = pwdata[COORD_WIDTH-1:0];
                REG_BOX_X_HIGH:       cfg_next.box_x_high = pwdata[COORD_WIDTH-1:0];
                REG_BOX_Y_LOW:        cfg_next.box_y_low  = pwdata[COORD_WIDTH-1:0];
                REG_BOX_Y_HIGH:       cfg_next.box_y_high = pwdata[COORD_WIDTH-1:0];
                REG_BOX_Z_LOW:        cfg_next.box_z_low  = pwdata[COORD_WIDTH-1:0];
                REG_BOX_Z_HIGH:       cfg_next.box_z_high = pwdata[COORD_WIDTH-1:0];
                REG_CLIP_MODE:        cfg_next.clip_mode  = pwdata[2:0];
                REG_TERMINATE_AT_END: cfg_next.terminate_at_end = pwdata[0];
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        unique case (idx)
            REG_BOX_X_LOW:        prdata = cfg_reg.box_x_low;
            REG_BOX_X_HIGH:       prdata = cfg_reg.box_x_high;
            REG_BOX_Y_LOW:        prdata = cfg_reg.box_y_low;
            REG_BOX_Y_HIGH:       prdata = cfg_reg.box_y_high;
            REG_BOX_Z_LOW:        prdata = cfg_reg.box_z_low;
            REG_BOX_Z_HIGH:       prdata = cfg_reg.box_z_high;
            REG_CLIP_MODE:        prdata = {{(DATA_W-3){1'b0}}, cfg_reg.clip_mode};
            REG_TERMINATE_AT_END: prdata = {{(DATA_W-1){1'b0}}, cfg_reg.terminate_at_end};
        endcase
    end

endmodule
`default_nettype wire

>>> sv/plvc_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plvc_datapath
// Vertex state, outcodes, edge terms, shared divider and multiplier, and the
// output register.
// ----------------------------------------------------------------------------
module plvc_datapath
    import plvc_pkg::*;
(
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire plvc_cfg_t               cfg,
    input  wire plvc_cmd_t               cmd,
    output plvc_status_t                 st,
    input  wire logic [COORD_WIDTH-1:0]  in_x,
    input  wire logic [COORD_WIDTH-1:0]  in_y,
    input  wire logic [COORD_WIDTH-1:0]  in_z,
    input  wire logic                    in_start,
    input  wire logic                    in_end,
    output logic                         m_valid,
    input  wire logic                    m_ready,
    output logic [1:0]                   m_op,
    output logic [PIXEL_WIDTH-1:0]       m_px,
    output logic [PIXEL_WIDTH-1:0]       m_py,
    output logic                         m_last
);

    function automatic logic [PIXEL_WIDTH-1:0] to_pixel(input logic signed [PT_W-1:0] v);
        logic signed [S_W-1:0] s;
        logic signed [S_W-1:0] r;
        logic signed [S_W-1:0] pmax;
        logic signed [S_W-1:0] pmin;
        s    = $signed({v[PT_W-1], v, 1'b0}) + $signed(S_W'(1) << COORD_FRAC_BITS);
        // round half up then truncate toward zero
        r    = (s >>> (COORD_FRAC_BITS + 1)) + $signed(S_W'(s[S_W-1]));
        pmax = $signed((S_W'(1) << (PIXEL_WIDTH - 1)) - S_W'(1));
        pmin = -pmax - $signed(S_W'(1));
        if (r > pmax) r = pmax;
        if (r < pmin) r = pmin;
        return r[PIXEL_WIDTH-1:0];
    endfunction

    logic signed [COORD_WIDTH-1:0] x2_reg, y2_reg, z2_reg;
    logic signed [COORD_WIDTH-1:0] x1_reg, y1_reg, z1_reg;
    logic                          end_reg;
    logic [5:0]                    prev_oc_reg, map_reg;
    logic                          disc_reg, mpend_reg;
    logic signed [DIFF_W-1:0]      dx_reg, dy_reg, dz_reg;
    logic signed [DIFF_W-1:0]      p_reg, q_reg;
    logic [T_W-1:0]                t0_reg, t1_reg, r_reg;
    logic [2:0]                    edge_reg;
    logic [MAG_W-1:0]              rem_reg, den_reg;
    logic [T_FRAC_BITS-1:0]        quo_reg;
    logic [CNT_W-1:0]              cnt_reg;
    logic                          pneg_reg;
    logic                          dneg_reg;
    logic [PLO_W-1:0]              plo_reg;
    logic [PHI_W-1:0]              phi_reg;
    logic signed [PT_W-1:0]        px_reg, py_reg;
    logic                          pt_sel_reg;
    logic                          mvalid_reg;
    logic [1:0]                    mop_reg;
    logic [PIXEL_WIDTH-1:0]        mpx_reg, mpy_reg;
    logic                          mlast_reg;

    logic [5:0]               oc;
    logic signed [DIFF_W-1:0] p_new, q_new;
    logic                     edge_en;
    logic [MAG_W-1:0]         pmag, qmag;
    edge_kind_t               kind;
    logic [MAG_W:0]           rem2;
    logic                     rem_ge;
    logic [T_FRAC_BITS-1:0]   quo_next;
    logic                     apply_rej;
    logic signed [DIFF_W-1:0] dsel;
    logic [MAG_W-1:0]         dmag;
    logic [T_W-1:0]           tsel;
    logic [PT_W-1:0]          sum;
    logic signed [PT_W-1:0]   base, ires;
    logic                     out_free;

    // outcode of the incoming vertex
    always_comb begin
        oc = '0;
        if (x2_reg < cfg.box_x_low)       oc = oc | OC_LEFT;
        else if (x2_reg > cfg.box_x_high) oc = oc | OC_RIGHT;
        if (y2_reg < cfg.box_y_low)       oc = oc | OC_BOTTOM;
        else if (y2_reg > cfg.box_y_high) oc = oc | OC_TOP;
        if (cfg.clip_mode[0] && z2_reg < cfg.box_z_low)  oc = oc | OC_NEAR;
        if (cfg.clip_mode[1] && z2_reg > cfg.box_z_high) oc = oc | OC_FAR;
    end

    // p and q of the current boundary
    always_comb begin
        unique case (edge_reg)
            3'd0: begin
                p_new = -dx_reg;
                q_new = DIFF_W'(x1_reg) - DIFF_W'(cfg.box_x_low);
            end
            3'd1: begin
                p_new = dx_reg;
                q_new = DIFF_W'(cfg.box_x_high) - DIFF_W'(x1_reg);
            end
            3'd2: begin
                p_new = -dy_reg;
                q_new = DIFF_W'(y1_reg) - DIFF_W'(cfg.box_y_low);
            end
            3'd3: begin
                p_new = dy_reg;
                q_new = DIFF_W'(cfg.box_y_high) - DIFF_W'(y1_reg);
            end
            3'd4: begin
                p_new = -dz_reg;
                q_new = DIFF_W'(z1_reg) - DIFF_W'(cfg.box_z_low);
            end
            default: begin
                p_new = dz_reg;
                q_new = DIFF_W'(cfg.box_z_high) - DIFF_W'(z1_reg);
            end
        endcase
    end

    assign edge_en = (edge_reg < EDGE_NEAR)
                  || (edge_reg == EDGE_NEAR && cfg.clip_mode[0])
                  || (edge_reg == EDGE_FAR  && cfg.clip_mode[1]);
    assign pmag = p_reg[DIFF_W-1] ? MAG_W'(-p_reg) : MAG_W'(p_reg);
    assign qmag = q_reg[DIFF_W-1] ? MAG_W'(-q_reg) : MAG_W'(q_reg);

    always_comb begin
        if (!edge_en) begin
            kind = EK_SKIP;
        end else if (p_reg < 0) begin
            if (q_reg > 0)            kind = EK_SKIP;
            else if (qmag >= pmag)    kind = EK_DIRECT;
            else                      kind = EK_DIV;
        end else if (p_reg > 0) begin
            if (q_reg < 0)            kind = EK_REJECT;
            else if (qmag >= pmag)    kind = EK_DIRECT;
            else                      kind = EK_DIV;
        end else begin
            kind = (q_reg < 0) ? EK_REJECT : EK_SKIP;
        end
    end

    // restoring divider, one quotient bit a step
    assign rem2     = {rem_reg, 1'b0};
    assign rem_ge   = rem2 >= {1'b0, den_reg};
    assign quo_next = {quo_reg[T_FRAC_BITS-2:0], rem_ge};

    assign apply_rej = pneg_reg ? (r_reg > t1_reg) : (r_reg < t0_reg);

    // interpolation through the shared multiplier
    assign dsel = cmd.axis ? dy_reg : dx_reg;
    assign dmag = dsel[DIFF_W-1] ? MAG_W'(-dsel) : MAG_W'(dsel);
    assign tsel = pt_sel_reg ? t1_reg : t0_reg;
    assign sum  = PT_W'(phi_reg) + PT_W'(plo_reg >> T_FRAC_BITS);
    assign base = cmd.axis ? PT_W'(y1_reg) : PT_W'(x1_reg);
    assign ires = dneg_reg ? base - $signed(sum) : base + $signed(sum);

    assign out_free = !mvalid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (cmd.load_vertex) begin
            x2_reg  <= in_x;
            y2_reg  <= in_y;
            z2_reg  <= in_z;
            end_reg <= in_end;
        end
        if (cmd.eval) begin
            map_reg <= oc;
            dx_reg  <= DIFF_W'(x2_reg) - DIFF_W'(x1_reg);
            dy_reg  <= DIFF_W'(y2_reg) - DIFF_W'(y1_reg);
            dz_reg  <= DIFF_W'(z2_reg) - DIFF_W'(z1_reg);
        end
        if (cmd.clip_init) begin
            t0_reg <= '0;
            t1_reg <= T_ONE;
        end else if (cmd.apply && !apply_rej) begin
            if (pneg_reg) begin
                if (r_reg > t0_reg) t0_reg <= r_reg;
            end else begin
                if (r_reg < t1_reg) t1_reg <= r_reg;
            end
        end
        if (cmd.edge_pq) begin
            p_reg <= p_new;
            q_reg <= q_new;
        end
        if (cmd.edge_chk) begin
            pneg_reg <= p_reg[DIFF_W-1];
            r_reg    <= (qmag > pmag) ? T_ONE_STEP : T_ONE;
            rem_reg  <= qmag;
            den_reg  <= pmag;
            quo_reg  <= '0;
            cnt_reg  <= '0;
        end else if (cmd.div_step) begin
            rem_reg <= rem_ge ? MAG_W'(rem2 - {1'b0, den_reg}) : MAG_W'(rem2);
            quo_reg <= quo_next;
            cnt_reg <= cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(T_FRAC_BITS - 1)) r_reg <= {1'b0, quo_next};
        end
        if (cmd.pt_load) begin
            pt_sel_reg <= cmd.pt_sel;
            px_reg     <= cmd.pt_sel ? PT_W'(x2_reg) : PT_W'(x1_reg);
            py_reg     <= cmd.pt_sel ? PT_W'(y2_reg) : PT_W'(y1_reg);
        end else if (cmd.mul_add) begin
            if (cmd.axis) py_reg <= ires;
            else          px_reg <= ires;
        end
        if (cmd.mul_lo) begin
            dneg_reg <= dsel[DIFF_W-1];
            plo_reg  <= PLO_W'(dmag[T_FRAC_BITS-1:0]) * PLO_W'(tsel);
        end
        if (cmd.mul_hi) begin
            phi_reg <= PHI_W'(dmag[MAG_W-1:T_FRAC_BITS]) * PHI_W'(tsel);
        end
        if (cmd.emit) begin
            mlast_reg <= cmd.emit_last;
            unique case (cmd.emit_sel)
                EMIT_MOVE: mop_reg <= OP_MOVE;
                EMIT_PEN:  mop_reg <= mpend_reg ? OP_MOVE : OP_DRAW;
                default:   mop_reg <= OP_TERM;
            endcase
            mpx_reg <= (cmd.emit_sel == EMIT_TERM) ? '0 : to_pixel(px_reg);
            mpy_reg <= (cmd.emit_sel == EMIT_TERM) ? '0 : to_pixel(py_reg);
        end
    end

    // control and reset-defined state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x1_reg      <= '0;
            y1_reg      <= '0;
            z1_reg      <= '0;
            prev_oc_reg <= '0;
            disc_reg    <= 1'b1;
            mpend_reg   <= 1'b1;
            edge_reg    <= '0;
            mvalid_reg  <= 1'b0;
        end else begin
            if (cmd.load_vertex && in_start) begin
                disc_reg    <= 1'b1;
                prev_oc_reg <= '0;
                mpend_reg   <= !cfg.clip_mode[2];
            end
            if (cmd.clr_move) mpend_reg <= 1'b0;
            if (cmd.commit) begin
                x1_reg      <= x2_reg;
                y1_reg      <= y2_reg;
                z1_reg      <= z2_reg;
                prev_oc_reg <= map_reg;
                disc_reg    <= 1'b0;
            end
            if (cmd.clip_init)      edge_reg <= '0;
            else if (cmd.edge_next) edge_reg <= edge_reg + 3'd1;
            if (cmd.emit)         mvalid_reg <= 1'b1;
            else if (m_ready)     mvalid_reg <= 1'b0;
        end
    end

    assign st.trivial_accept = (map_reg | prev_oc_reg) == '0;
    assign st.trivial_reject = ((map_reg & prev_oc_reg) != '0) || disc_reg;
    assign st.edge_kind      = kind;
    assign st.div_done       = cnt_reg == CNT_W'(T_FRAC_BITS - 1);
    assign st.apply_reject   = apply_rej;
    assign st.last_edge      = edge_reg == EDGE_LAST;
    assign st.prev_oc_nz     = prev_oc_reg != '0;
    assign st.start_interp   = t0_reg != '0;
    assign st.end_interp     = t1_reg < T_ONE;
    assign st.out_free       = out_free;
    assign st.end_term       = end_reg && cfg.terminate_at_end;

    assign m_valid = mvalid_reg;
    assign m_op    = mop_reg;
    assign m_px    = mpx_reg;
    assign m_py    = mpy_reg;
    assign m_last  = mlast_reg;

endmodule
`default_nettype wire

>>> sv/plvc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plvc_ctrl
// Sequencer: classify, clip boundary by boundary, interpolate, emit.
// ----------------------------------------------------------------------------
module plvc_ctrl
    import plvc_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire plvc_status_t st,
    output plvc_cmd_t         cmd
);

    typedef enum logic [15:0] {
        S_IDLE   = 16'h0001,
        S_EVAL   = 16'h0002,
        S_DECIDE = 16'h0004,
        S_PQ     = 16'h0008,
        S_CHK    = 16'h0010,
        S_DIV    = 16'h0020,
        S_APPLY  = 16'h0040,
        S_ETERM  = 16'h0080,
        S_PLOAD  = 16'h0100,
        S_MLO    = 16'h0200,
        S_MHI    = 16'h0400,
        S_MADD   = 16'h0800,
        S_SEMIT  = 16'h1000,
        S_EEMIT  = 16'h2000,
        S_COMMIT = 16'h4000,
        S_FTERM  = 16'h8000
    } state_t;

    state_t state_reg, state_next;
    logic   sel_reg, sel_next;
    logic   axis_reg, axis_next;
    state_t clip_done;
    state_t pt_done;

    assign in_ready  = state_reg == S_IDLE;
    assign clip_done = st.prev_oc_nz ? S_ETERM : S_PLOAD;
    assign pt_done   = sel_reg ? S_EEMIT : S_SEMIT;

    always_comb begin
        state_next = state_reg;
        sel_next   = sel_reg;
        axis_next  = axis_reg;
        cmd        = '0;
        cmd.pt_sel = sel_reg;
        cmd.axis   = axis_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    cmd.load_vertex = 1'b1;
                    state_next      = S_EVAL;
                end
            end
            S_EVAL: begin
                cmd.eval   = 1'b1;
                state_next = S_DECIDE;
            end
            S_DECIDE: begin
                priority if (st.trivial_accept) begin
                    cmd.pt_load = 1'b1;
                    cmd.pt_sel  = 1'b1;
                    state_next  = S_EEMIT;
                end else if (st.trivial_reject) begin
                    state_next = S_COMMIT;
                end else begin
                    cmd.clip_init = 1'b1;
                    sel_next      = !st.prev_oc_nz;
                    state_next    = S_PQ;
                end
            end
            S_PQ: begin
                cmd.edge_pq = 1'b1;
                state_next  = S_CHK;
            end
            S_CHK: begin
                cmd.edge_chk = 1'b1;
                unique case (st.edge_kind)
                    EK_SKIP: begin
                        cmd.edge_next = 1'b1;
                        state_next    = st.last_edge ? clip_done : S_PQ;
                    end
                    EK_REJECT: state_next = S_COMMIT;
                    EK_DIRECT: state_next = S_APPLY;
                    default:   state_next = S_DIV;
                endcase
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (st.div_done) state_next = S_APPLY;
            end
            S_APPLY: begin
                cmd.apply = 1'b1;
                if (st.apply_reject) begin
                    state_next = S_COMMIT;
                end else begin
                    cmd.edge_next = 1'b1;
                    state_next    = st.last_edge ? clip_done : S_PQ;
                end
            end
            S_ETERM: begin
                if (st.out_free) begin
                    cmd.emit     = 1'b1;
                    cmd.emit_sel = EMIT_TERM;
                    state_next   = S_PLOAD;
                end
            end
            S_PLOAD: begin
                cmd.pt_load = 1'b1;
                axis_next   = 1'b0;
                if (sel_reg ? st.end_interp : st.start_interp) state_next = S_MLO;
                else                                           state_next = pt_done;
            end
            S_MLO: begin
                cmd.mul_lo = 1'b1;
                state_next = S_MHI;
            end
            S_MHI: begin
                cmd.mul_hi = 1'b1;
                state_next = S_MADD;
            end
            S_MADD: begin
                cmd.mul_add = 1'b1;
                if (!axis_reg) begin
                    axis_next  = 1'b1;
                    state_next = S_MLO;
                end else begin
                    state_next = pt_done;
                end
            end
            S_SEMIT: begin
                if (st.out_free) begin
                    cmd.emit     = 1'b1;
                    cmd.emit_sel = EMIT_MOVE;
                    cmd.clr_move = 1'b1;
                    sel_next     = 1'b1;
                    state_next   = S_PLOAD;
                end
            end
            S_EEMIT: begin
                if (st.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_sel  = EMIT_PEN;
                    cmd.emit_last = !st.end_term;
                    cmd.clr_move  = 1'b1;
                    state_next    = S_COMMIT;
                end
            end
            S_COMMIT: begin
                cmd.commit = 1'b1;
                state_next = st.end_term ? S_FTERM : S_IDLE;
            end
            S_FTERM: begin
                if (st.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_sel  = EMIT_TERM;
                    cmd.emit_last = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            sel_reg   <= 1'b0;
            axis_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
            axis_reg  <= axis_next;
        end
    end

endmodule
`default_nettype wire
